// ===== hw/rtl/rtlpm_pkg.sv =====
// ----------------------------------------------------------------------------
// rtlpm_pkg: shared types and constants for the longest-prefix route table
// Table depth, beat layouts, stored entry format, sequencer states.
// ----------------------------------------------------------------------------
package rtlpm_pkg;

  // table depth (entries)
  localparam int CAPACITY = 64;
  // entry index width and entry count width (count must hold CAPACITY)
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [31:0] EXPIRE_RST = 32'd16000;

  // tdata widths, padded to whole bytes
  localparam int IN_W  = 168;
  localparam int OUT_W = 136;

  // operation codes carried on in_tuser
  localparam logic OP_QUERY  = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  typedef struct packed {
    logic        stat;
    logic [31:0] tim;
    logic [31:0] dat;
    logic [31:0] msk;
    logic [31:0] dst;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

endpackage

// ===== hw/rtl/rtlpm_ram.sv =====
// ----------------------------------------------------------------------------
// rtlpm_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rtlpm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/route_table_longest_prefix_core.sv =====
// ----------------------------------------------------------------------------
// route_table_longest_prefix_core: IPv4 route table, longest-prefix lookup
// Update/insert and query over a table of up to rtlpm_pkg::CAPACITY routes.
// ----------------------------------------------------------------------------
// Each beat is either a query (in_tuser = 0) or an update (in_tuser = 1).
// Both walk the stored entries one per cycle through a single read port of
// the entry RAM, with one compare unit looking at each entry as it comes
// back. After the accepting edge an item reads each stored entry, waits for
// the last read to land and closes the scan; then ST_FINISH loads the output
// register once it is free or out_tready is high. An empty table has no read
// in flight. The entry scan sets most of the time that an item takes.
// in_tready is high only while the sequencer is idle. The result
// beat sits in an output register, so the next item is taken while a result
// still waits on out_tready. A query returns the live matching route with the
// widest mask (later entry wins a tie); an update overwrites the entry with
// the same destination and mask, or appends one, or reports table_full.
// expire_ms (cfg_wr_data) must only be written while no item is in flight.
module route_table_longest_prefix_core (
  input  logic                          clk,
  input  logic                          rst_n,
  // input beats
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // tdata, low bit up: address[31:0], prefix_mask[63:32], route_data[95:64],
  // entry_time[127:96], is_static[128], now_ms[160:129], zero pad[167:161]
  input  logic [rtlpm_pkg::IN_W-1:0]    in_tdata,
  // tuser: operation (0 query, 1 update)
  input  logic                          in_tuser,
  // result beats
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // tdata, low bit up: found[0], inserted[1], table_full[2], hit_dest[34:3],
  // hit_mask[66:35], hit_data[98:67], hit_time[130:99], hit_static[131],
  // zero pad[135:132]
  output logic [rtlpm_pkg::OUT_W-1:0]   out_tdata,
  // expire_ms register
  input  logic                          cfg_wr_en,
  input  logic [31:0]                   cfg_wr_data
);

  localparam int AW = rtlpm_pkg::AW;
  localparam int CW = rtlpm_pkg::CW;

  rtlpm_pkg::state_t state_r, state_nxt;

  // control
  logic [CW-1:0] cnt_r, cnt_nxt;       // valid entries
  logic [CW-1:0] idx_r, idx_nxt;       // next entry to read
  logic          pend_r, pend_nxt;     // read data valid this cycle
  logic [AW-1:0] pidx_r, pidx_nxt;     // index of that read data
  logic          out_valid_r, out_valid_nxt;
  logic [31:0]   expire_r;

  // held item
  logic          op_r, op_nxt;
  logic [31:0]   addr_r, addr_nxt;
  logic [31:0]   mask_r, mask_nxt;
  logic [31:0]   data_r, data_nxt;
  logic [31:0]   time_r, time_nxt;
  logic          stat_r, stat_nxt;
  logic [31:0]   now_r, now_nxt;

  // query choice so far
  logic          have_r, have_nxt;
  rtlpm_pkg::entry_t best_r, best_nxt;

  // update: first exact match
  logic          hit_r, hit_nxt;
  logic [AW-1:0] hidx_r, hidx_nxt;

  logic [rtlpm_pkg::OUT_W-1:0] out_data_r, out_data_nxt;

  // entry RAM
  logic                          ram_we, ram_re;
  logic [AW-1:0]                 ram_waddr, ram_raddr;
  logic [rtlpm_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;
  rtlpm_pkg::entry_t             rd_e, wr_e;

  // compare unit on the returning entry
  logic [31:0] age;
  logic        pfx_match, live, covers, exact;

  rtlpm_ram #(
    .WIDTH (rtlpm_pkg::ENTRY_W),
    .DEPTH (rtlpm_pkg::CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_e      = rtlpm_pkg::entry_t'(ram_rdata);
  assign ram_wdata = wr_e;
  assign ram_raddr = idx_r[AW-1:0];

  assign age       = now_r - rd_e.tim;            // wraps mod 2^32
  assign pfx_match = ((rd_e.dst ^ addr_r) & rd_e.msk) == 32'd0;
  assign live      = rd_e.stat || (age <= expire_r);
  assign covers    = (rd_e.msk & best_r.msk) == best_r.msk;
  assign exact     = (rd_e.dst == addr_r) && (rd_e.msk == mask_r);

  assign in_tready  = (state_r == rtlpm_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rtlpm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      expire_r    <= rtlpm_pkg::EXPIRE_RST;
    end else begin
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        expire_r <= cfg_wr_data;
      end
    end
  end

  // payload and scan bookkeeping, no reset needed
  always_ff @(posedge clk) begin
    pidx_r     <= pidx_nxt;
    op_r       <= op_nxt;
    addr_r     <= addr_nxt;
    mask_r     <= mask_nxt;
    data_r     <= data_nxt;
    time_r     <= time_nxt;
    stat_r     <= stat_nxt;
    now_r      <= now_nxt;
    have_r     <= have_nxt;
    best_r     <= best_nxt;
    hit_r      <= hit_nxt;
    hidx_r     <= hidx_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    pend_nxt      = pend_r;
    pidx_nxt      = pidx_r;
    op_nxt        = op_r;
    addr_nxt      = addr_r;
    mask_nxt      = mask_r;
    data_nxt      = data_r;
    time_nxt      = time_r;
    stat_nxt      = stat_r;
    now_nxt       = now_r;
    have_nxt      = have_r;
    best_nxt      = best_r;
    hit_nxt       = hit_r;
    hidx_nxt      = hidx_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    ram_re        = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = hidx_r;
    wr_e          = '{stat: stat_r, tim: time_r, dat: data_r, msk: mask_r, dst: addr_r};

    unique case (state_r)
      rtlpm_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          op_nxt    = in_tuser;
          addr_nxt  = in_tdata[31:0];
          mask_nxt  = in_tdata[63:32];
          data_nxt  = in_tdata[95:64];
          time_nxt  = in_tdata[127:96];
          stat_nxt  = in_tdata[128];
          now_nxt   = in_tdata[160:129];
          idx_nxt   = '0;
          pend_nxt  = 1'b0;
          have_nxt  = 1'b0;
          best_nxt  = '0;
          hit_nxt   = 1'b0;
          hidx_nxt  = '0;
          state_nxt = rtlpm_pkg::ST_SCAN;
        end
      end

      rtlpm_pkg::ST_SCAN: begin
        // issue side
        pend_nxt = 1'b0;
        if (idx_r < cnt_r) begin
          ram_re   = 1'b1;
          idx_nxt  = idx_r + CW'(1);
          pidx_nxt = idx_r[AW-1:0];
          pend_nxt = 1'b1;
        end else if (!pend_r) begin
          state_nxt = rtlpm_pkg::ST_FINISH;
        end
        // compare side
        if (pend_r) begin
          if (op_r == rtlpm_pkg::OP_QUERY) begin
            if (pfx_match && live && covers) begin
              have_nxt = 1'b1;
              best_nxt = rd_e;
            end
          end else if (exact && !hit_r) begin
            hit_nxt  = 1'b1;
            hidx_nxt = pidx_r;
          end
        end
      end

      rtlpm_pkg::ST_FINISH: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = rtlpm_pkg::ST_IDLE;
          out_data_nxt  = '0;
          if (op_r == rtlpm_pkg::OP_QUERY) begin
            if (have_r) begin
              out_data_nxt[0]       = 1'b1;
              out_data_nxt[34:3]    = best_r.dst;
              out_data_nxt[66:35]   = best_r.msk;
              out_data_nxt[98:67]   = best_r.dat;
              out_data_nxt[130:99]  = best_r.tim;
              out_data_nxt[131]     = best_r.stat;
            end
          end else if (hit_r) begin
            ram_we = 1'b1;                      // overwrite in place
          end else if (cnt_r < CW'(rtlpm_pkg::CAPACITY)) begin
            ram_we          = 1'b1;             // append
            ram_waddr       = cnt_r[AW-1:0];
            cnt_nxt         = cnt_r + CW'(1);
            out_data_nxt[1] = 1'b1;
          end else begin
            out_data_nxt[2] = 1'b1;             // dropped, table full
          end
        end
      end

      default: begin
        state_nxt = rtlpm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/rtlpm_checker.sv =====
// ----------------------------------------------------------------------------
// rtlpm_checker: port-level checks for the route table
// Result flag consistency, handshake and sequencing checks, bound to the core.
// ----------------------------------------------------------------------------
module rtlpm_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [rtlpm_pkg::OUT_W-1:0] out_tdata
);

  // a stalled result beat stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  // no result beat right after reset
  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result beat after reset");

  // one item at a time: accepting closes the input until the result is loaded
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while busy");

  // found, inserted and table_full are mutually exclusive
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $onehot0(out_tdata[2:0]))
    else $error("conflicting result flags");

  // without a hit all route fields read zero
  a_no_hit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[rtlpm_pkg::OUT_W-1:3] == '0)
    else $error("route fields set without a hit");

endmodule

bind route_table_longest_prefix_core rtlpm_checker u_rtlpm_checker (.*);
